// ----- hdl/epdf_pkg.sv -----
// ----------------------------------------------------------------------------
// epdf_pkg
// shared types, constants and terminal data table of the pdol data filler
// ----------------------------------------------------------------------------
package epdf_pkg;

	localparam int MAX_RUN     = 64;
	localparam int CNT_W       = $clog2(MAX_RUN + 1);
	localparam int ENTRY_COUNT = 13;
	localparam int NO_MATCH    = 13;
	localparam int ENTRY_W     = 4;
	localparam int VAL_BYTES   = 6;
	localparam int VAL_W       = VAL_BYTES * 8;

	typedef struct packed {
		logic [7:0] list_byte;
		logic       list_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0] fill_byte;
		logic       run_last;
		logic       truncated;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic emit;
	} epdf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic run_start;
		logic run_done;
		logic out_free;
	} epdf_sts_t;

	// terminal data table, value bytes left aligned, zeros past the stored part
	localparam logic [15:0] ROM_TAG [ENTRY_COUNT] = '{
		16'h9F59, 16'h9F5A, 16'h9F58, 16'h9F66, 16'h9F02, 16'h9F03, 16'h9F1A,
		16'h5F2A, 16'h0095, 16'h009A, 16'h009C, 16'h0098, 16'h9F37
	};

	localparam logic [4:0] ROM_LEN [ENTRY_COUNT] = '{
		5'd3, 5'd1, 5'd1, 5'd4, 5'd6, 5'd6, 5'd2, 5'd2, 5'd5, 5'd3, 5'd1, 5'd20, 5'd4
	};

	localparam logic [VAL_W-1:0] ROM_VAL [ENTRY_COUNT] = '{
		48'hC8_80_00_00_00_00,
		48'h00_00_00_00_00_00,
		48'h01_00_00_00_00_00,
		48'h79_00_40_80_00_00,
		48'h00_00_00_10_00_00,
		48'h00_00_00_00_00_00,
		48'h01_24_00_00_00_00,
		48'h01_24_00_00_00_00,
		48'h00_00_00_00_00_00,
		48'h19_01_01_00_00_00,
		48'h00_00_00_00_00_00,
		48'h00_00_00_00_00_00,
		48'h82_3D_DE_7A_00_00
	};

	// first entry in table order whose tag matches, NO_MATCH otherwise
	function automatic logic [ENTRY_W-1:0] rom_lookup(input logic [15:0] tag);
		logic [ENTRY_W-1:0] r;
		r = ENTRY_W'(NO_MATCH);
		for (int j = ENTRY_COUNT - 1; j >= 0; j--) begin
			if (ROM_TAG[j] == tag) begin
				r = ENTRY_W'(j);
			end
		end
		return r;
	endfunction

	// byte idx of an entry's answer, zero past its end or for no match
	function automatic logic [7:0] rom_byte(input logic [ENTRY_W-1:0] entry,
		input logic [CNT_W-1:0] idx);
		logic [7:0]       r;
		logic [VAL_W-1:0] v;
		r = 8'h00;
		v = '0;
		if (entry < ENTRY_W'(ENTRY_COUNT)) begin
			v = ROM_VAL[entry];
			if (idx < CNT_W'(ROM_LEN[entry])) begin
				for (int i = 0; i < VAL_BYTES; i++) begin
					if (idx == CNT_W'(i)) begin
						r = v[(VAL_BYTES - 1 - i) * 8 +: 8];
					end
				end
			end
		end
		return r;
	endfunction

endpackage

// ----- hdl/epdf_ctrl.sv -----
// ----------------------------------------------------------------------------
// epdf_ctrl
// controller: takes list bytes while parsing, steps the datapath through a run
// ----------------------------------------------------------------------------
module epdf_ctrl import epdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  epdf_sts_t sts,
	output epdf_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_PARSE = 2'b01,
		ST_EMIT  = 2'b10
	} ctl_state_t;

	ctl_state_t state_q;
	ctl_state_t state_d;

	assign in_stall   = (state_q != ST_PARSE);
	assign cmd.accept = in_valid && (state_q == ST_PARSE);
	assign cmd.emit   = (state_q == ST_EMIT) && sts.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_PARSE: begin
				if (cmd.accept && sts.run_start) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.emit && sts.run_done) begin
					state_d = ST_PARSE;
				end
			end
			default: state_d = ST_PARSE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PARSE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hdl/epdf_datapath.sv -----
// ----------------------------------------------------------------------------
// epdf_datapath
// tag parser, table lookup, run counter and output register
// ----------------------------------------------------------------------------
module epdf_datapath import epdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  in_data,
	input  epdf_cmd_t cmd,
	output epdf_sts_t sts,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_LENGTH = 3'b100
	} phase_t;

	phase_t             phase_q;
	logic [ENTRY_W-1:0] matched_q;
	logic [7:0]         first_q;
	logic [ENTRY_W-1:0] run_entry_q;
	logic [CNT_W-1:0]   run_len_q;
	logic               run_trunc_q;
	logic [CNT_W-1:0]   idx_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [ENTRY_W-1:0] short_hit;
	logic [ENTRY_W-1:0] long_hit;
	logic               over_cap;
	logic [CNT_W-1:0]   idx_next;

	assign short_hit = rom_lookup({8'h00, in_data.list_byte});
	assign long_hit  = rom_lookup({first_q, in_data.list_byte});
	assign over_cap  = (in_data.list_byte > 8'(MAX_RUN));
	assign idx_next  = idx_q + CNT_W'(1);

	assign sts.run_start = (phase_q == PH_LENGTH) && (in_data.list_byte != 8'h00);
	assign sts.run_done  = (idx_next == run_len_q);
	assign sts.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_FIRST;
			matched_q <= ENTRY_W'(NO_MATCH);
			first_q   <= 8'h00;
		end else if (cmd.accept) begin
			if (in_data.list_end) begin
				phase_q   <= PH_FIRST;
				matched_q <= ENTRY_W'(NO_MATCH);
				first_q   <= 8'h00;
			end else begin
				case (phase_q)
					PH_SECOND: begin
						matched_q <= long_hit;
						phase_q   <= PH_LENGTH;
					end
					PH_LENGTH: begin
						matched_q <= ENTRY_W'(NO_MATCH);
						phase_q   <= PH_FIRST;
					end
					default: begin
						if (short_hit != ENTRY_W'(NO_MATCH)) begin
							matched_q <= short_hit;
							phase_q   <= PH_LENGTH;
						end else begin
							first_q <= in_data.list_byte;
							phase_q <= PH_SECOND;
						end
					end
				endcase
			end
		end
	end

	// run setup and byte counter
	always_ff @(posedge clk) begin
		if (cmd.accept && (phase_q == PH_LENGTH)) begin
			run_entry_q <= matched_q;
			run_trunc_q <= over_cap;
			run_len_q   <= over_cap ? CNT_W'(MAX_RUN) : CNT_W'(in_data.list_byte);
			idx_q       <= '0;
		end else if (cmd.emit) begin
			idx_q <= idx_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.fill_byte <= rom_byte(run_entry_q, idx_q);
			out_q.run_last  <= sts.run_done;
			out_q.truncated <= run_trunc_q;
		end
	end

endmodule

// ----- hdl/emv_pdol_data_filler.sv -----
// ----------------------------------------------------------------------------
// emv_pdol_data_filler
// builds the pdol data field from a card's tag-length list; when not stalled, one byte a cycle
// ----------------------------------------------------------------------------
//
//   channel   direction   payload      handshake
//   in        input       in_item_t    in_valid / in_stall
//   out       output      out_item_t   out_valid / out_stall
//
// a tag byte is taken and gives no transaction
// a length byte L starts a run of min(L, MAX_RUN) emitted bytes, counted by the run
// counter and sent through the single output register
// in_stall is high for the whole run; a zero length gives no run
// arst_n clears the parser to the first tag byte and empties the output register
// out_stall on a valid output holds the output register and pauses the run counter
//
module emv_pdol_data_filler import epdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	// command and status between controller and datapath
	epdf_cmd_t cmd;
	epdf_sts_t sts;

	// controller: parse state while taking bytes, emit state during a run
	epdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: tag parser, table lookup, run counter, output register
	epdf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// a length byte that starts a run blocks the next input transaction
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && sts.run_start) |=> in_stall)
		else $error("input taken right after a run started");

	// a stalled output transaction stays valid and keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled output transaction changed");

	// no byte is emitted while the block is taking list bytes, unless held over
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_stall && !out_valid) |=> !out_valid || $past(in_valid && sts.run_start))
		else $error("output byte appeared without a run");

endmodule
